// ----- rtl/htm_sol_pkg.sv -----
// Shared types and constants for the HTM dendrite segment overlap/learn block.
package htm_sol_pkg;

  localparam int NUM_INPUTS = 1024;
  localparam int POS_W      = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam int PERM_W     = 8;
  localparam int ACC_W      = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [PERM_W-1:0] PERM_MAX = '1;
  localparam logic [ACC_W-1:0]  ACC_MAX  = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INCREMENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECREMENT = 2'd2;

  // command field codes
  localparam logic [1:0] CMD_OVERLAP = 2'd0;
  localparam logic [1:0] CMD_FIT     = 2'd1;
  localparam logic [1:0] CMD_LOAD    = 2'd2;

  typedef enum logic [1:0] {
    OP_OVERLAP,
    OP_FIT,
    OP_LOAD,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              input_bit;
    logic [PERM_W-1:0] load_value;
    logic              last_bit;
    logic [POS_W-1:0]  addr;
  } item_t;

  typedef struct packed {
    logic [PERM_W-1:0] threshold;
    logic [PERM_W-1:0] increment;
    logic [PERM_W-1:0] decrement;
  } cfg_t;

  typedef struct packed {
    logic [PERM_W-1:0] permanence;
    logic              connected;
    logic [ACC_W-1:0]  overlap;
    logic              pass_done;
  } res_t;

endpackage

// ----- rtl/htm_sol_front.sv -----
// Front end: accepts input transfers, decodes the command and tracks the position.
module htm_sol_front import htm_sol_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        q_full,
  input  logic [1:0]  cmd,
  input  logic        input_bit,
  input  logic [PERM_W-1:0] load_value,
  input  logic        last_bit,
  output logic        push,
  output item_t       push_item
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W:0]   pos_inc;
  op_t              op;

  always_comb begin
    case (cmd)
      CMD_OVERLAP: op = OP_OVERLAP;
      CMD_FIT:     op = OP_FIT;
      CMD_LOAD:    op = OP_LOAD;
      default:     op = OP_NOP;
    endcase
  end

  assign push    = in_valid && !q_full;
  assign pos_inc = {1'b0, pos_r} + {{POS_W{1'b0}}, 1'b1};

  always_comb begin
    pos_nxt = pos_r;
    if (push) begin
      if (last_bit || (pos_inc >= (POS_W+1)'(NUM_INPUTS))) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_inc[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_comb begin
    push_item.op         = op;
    push_item.input_bit  = input_bit;
    push_item.load_value = load_value;
    push_item.last_bit   = last_bit;
    push_item.addr       = pos_r;
  end

endmodule

// ----- rtl/htm_sol_queue.sv -----
// Two-entry queue between the front end and the read-modify-write back end.
module htm_sol_queue import htm_sol_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  head_valid,
  output item_t head_item
);

  item_t       ent_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- rtl/htm_sol_back.sv -----
// Back end: permanence memory, read-modify-write, overlap count and output register.
module htm_sol_back import htm_sol_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  head_valid,
  input  item_t head_item,
  output logic  pop,
  output logic  out_valid,
  input  logic  out_stall,
  output res_t  out_res
);

  logic [PERM_W-1:0] mem [NUM_INPUTS];
  logic [PERM_W-1:0] mem_q;

  logic              s1_valid_r;
  item_t             s1_item_r;
  logic              byp_r;
  logic [PERM_W-1:0] byp_data_r;
  logic [ACC_W-1:0]  acc_r;
  logic              out_valid_r;
  res_t              out_res_r;

  logic              advance;
  logic              wr_en;
  logic              hit;
  logic [PERM_W-1:0] perm_rd;
  logic [PERM_W-1:0] perm_new;
  logic [PERM_W:0]   perm_sum;
  logic [ACC_W-1:0]  acc_new;

  assign advance = s1_valid_r && (!out_valid_r || !out_stall);
  assign pop     = head_valid && (!s1_valid_r || advance);
  assign perm_rd = byp_r ? byp_data_r : mem_q;
  assign perm_sum = {1'b0, perm_rd} + {1'b0, cfg.increment};

  always_comb begin
    case (s1_item_r.op)
      OP_FIT: begin
        if (s1_item_r.input_bit) begin
          perm_new = perm_sum[PERM_W] ? PERM_MAX : perm_sum[PERM_W-1:0];
        end else begin
          perm_new = (perm_rd > cfg.decrement) ? perm_rd - cfg.decrement : '0;
        end
      end
      OP_LOAD: perm_new = s1_item_r.load_value;
      default: perm_new = perm_rd;
    endcase
  end

  assign wr_en = advance && ((s1_item_r.op == OP_FIT) || (s1_item_r.op == OP_LOAD));
  assign hit   = (s1_item_r.op == OP_OVERLAP) && s1_item_r.input_bit &&
                 (perm_rd >= cfg.threshold) && (acc_r != ACC_MAX);
  assign acc_new = acc_r + {{(ACC_W-1){1'b0}}, hit};

  // memory: read for the item entering stage 1, write for the item leaving it
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_item_r.addr] <= perm_new;
    end
    if (pop) begin
      mem_q <= mem[head_item.addr];
    end
  end

  // same-address write and read in one cycle: forward the written value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (pop) begin
      byp_r <= wr_en && (s1_item_r.addr == head_item.addr);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      byp_data_r <= perm_new;
      s1_item_r  <= head_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      if (pop) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        acc_r       <= s1_item_r.last_bit ? '0 : acc_new;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r.permanence <= perm_new;
      out_res_r.connected  <= (perm_new >= cfg.threshold);
      out_res_r.overlap    <= acc_new;
      out_res_r.pass_done  <= s1_item_r.last_bit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ----- rtl/htm_segment_overlap_and_learn.sv -----
// Top level of the HTM dendrite segment: config registers, front end, queue and back end.
//
// Usage:
//   Input channel (in_valid / in_stall): one transfer per input vector position, in order,
//   carrying the command (overlap, fit, load), the input bit, a load value and a last flag.
//   Result channel (out_valid / out_stall): exactly one result transfer per input transfer,
//   in order: permanence after the operation, connected flag, running overlap, pass_done.
//   Config port (cfg_we / cfg_index / cfg_data): write threshold, increment, decrement
//   while no items are in flight.
// Path: an accepted item passes through the two-entry queue, the stage 1 register and the
//   result register before its result is offered on the result channel.
// Throughput: one item per cycle while the receiver does not stall; each item does one
//   read-modify-write of the permanence memory (one read and one write port), with
//   forwarding between back-to-back items.
// Reset: position and overlap clear, config returns to 128 / 8 / 4. The permanence
//   memory is not cleared; load every position before using it.
// Receiver stall: the result register holds; the back end stops and the two-entry
//   queue fills, after which in_stall rises until results drain.
module htm_segment_overlap_and_learn import htm_sol_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_cmd,
  input  logic                 in_input_bit,
  input  logic [PERM_W-1:0]    in_load_value,
  input  logic                 in_last_bit,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PERM_W-1:0]    out_permanence_out,
  output logic                 out_connected,
  output logic [ACC_W-1:0]     out_overlap_count,
  output logic                 out_pass_done,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PERM_W-1:0]    cfg_data
);

  cfg_t  cfg_r;
  logic  push, pop, q_full, head_valid;
  item_t push_item, head_item;
  res_t  res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= 8'd128;
      cfg_r.increment <= 8'd8;
      cfg_r.decrement <= 8'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: cfg_r.threshold <= cfg_data;
        CFG_INCREMENT: cfg_r.increment <= cfg_data;
        CFG_DECREMENT: cfg_r.decrement <= cfg_data;
        default: ;
      endcase
    end
  end

  htm_sol_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .q_full     (q_full),
    .cmd        (in_cmd),
    .input_bit  (in_input_bit),
    .load_value (in_load_value),
    .last_bit   (in_last_bit),
    .push       (push),
    .push_item  (push_item)
  );

  htm_sol_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  htm_sol_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (res)
  );

  assign in_stall           = q_full;
  assign out_permanence_out = res.permanence;
  assign out_connected      = res.connected;
  assign out_overlap_count  = res.overlap;
  assign out_pass_done      = res.pass_done;

endmodule

// ----- test/htm_segment_overlap_and_learn_test.sv -----
// Self-checking testbench for the HTM dendrite segment overlap/learn block.
module htm_segment_overlap_and_learn_test import htm_sol_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned LONG_HOLD   = 300;

  typedef struct {
    op_t               op;
    logic              in_bit;
    logic [PERM_W-1:0] load_v;
    logic              last;
  } seg_bit_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_cmd = CMD_OVERLAP;
  logic                 in_input_bit = 1'b0;
  logic [PERM_W-1:0]    in_load_value = '0;
  logic                 in_last_bit = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PERM_W-1:0]    out_permanence_out;
  logic                 out_connected;
  logic [ACC_W-1:0]     out_overlap_count;
  logic                 out_pass_done;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_THRESHOLD;
  logic [PERM_W-1:0]    cfg_data = '0;

  htm_segment_overlap_and_learn dut (.*);

  always #2 clk = ~clk;

  // stimulus and expected results
  seg_bit_t pending_bits_q[$];
  res_t     expected_segment_q[$];

  // predictor copy of the segment
  logic [PERM_W-1:0] perm_mem [NUM_INPUTS];
  logic [POS_W-1:0]  seg_pos;
  logic [ACC_W-1:0]  seg_acc;
  logic [PERM_W-1:0] conn_thr, step_up, step_down;

  // generator bookkeeping: position and which entries hold a loaded value
  int unsigned gen_pos = 0;
  bit          loaded [NUM_INPUTS];

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned tx_gap = 0, tx_mode = 0, tx_mode_left = 0;
  int unsigned rx_run = 0, rx_mode = 0, rx_mode_left = 0;
  int unsigned hold_left = 0, next_hold = 400;
  seg_bit_t    drive_bit;
  res_t        want;

  function automatic int unsigned rand_gap(int unsigned mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (r < ((mode == 1) ? 70 : 40)) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic log_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // one read-modify-write of the segment for one accepted bit
  task automatic predict_segment(op_t op, logic in_bit, logic [PERM_W-1:0] load_v,
                                 logic last);
    logic [PERM_W:0]   sum;
    logic [PERM_W-1:0] p;
    res_t              r;
    p = perm_mem[seg_pos];
    case (op)
      OP_OVERLAP: begin
        if (in_bit && p >= conn_thr && seg_acc != ACC_MAX) seg_acc = seg_acc + ACC_W'(1);
      end
      OP_FIT: begin
        if (in_bit) begin
          sum = {1'b0, p} + {1'b0, step_up};
          p = (sum > {1'b0, PERM_MAX}) ? PERM_MAX : sum[PERM_W-1:0];
        end else begin
          p = (p > step_down) ? p - step_down : '0;
        end
        perm_mem[seg_pos] = p;
      end
      OP_LOAD: begin
        p = load_v;
        perm_mem[seg_pos] = p;
      end
      default: ;
    endcase
    r.permanence = p;
    r.connected  = (p >= conn_thr);
    r.overlap    = seg_acc;
    r.pass_done  = last;
    expected_segment_q.insert(expected_segment_q.size(), r);
    if (last) begin
      seg_pos = '0;
      seg_acc = '0;
    end else begin
      seg_pos = (seg_pos == POS_W'(NUM_INPUTS - 1)) ? '0 : seg_pos + POS_W'(1);
    end
  endtask

  // never read an entry that has not been loaded: such a bit becomes a load
  task automatic queue_bit(op_t op, logic in_bit, logic [PERM_W-1:0] load_v, logic last);
    seg_bit_t b;
    if (op != OP_LOAD && !loaded[gen_pos]) op = OP_LOAD;
    b.op = op;
    b.in_bit = in_bit;
    b.load_v = load_v;
    b.last = last;
    pending_bits_q.insert(pending_bits_q.size(), b);
    if (op == OP_LOAD) loaded[gen_pos] = 1'b1;
    gen_pos = last ? 0 : (gen_pos + 1) % NUM_INPUTS;
  endtask

  task automatic queue_pass(int unsigned len);
    int unsigned r;
    op_t op;
    for (int unsigned i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) op = OP_OVERLAP;
      else if (r < 78) op = OP_FIT;
      else if (r < 95) op = OP_LOAD;
      else op = OP_NOP;
      queue_bit(op, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  task automatic wait_idle();
    while (pending_bits_q.size() != 0 || in_valid || expected_segment_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PERM_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_THRESHOLD: conn_thr = val;
      CFG_INCREMENT: step_up = val;
      CFG_DECREMENT: step_down = val;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [PERM_W-1:0] thr, logic [PERM_W-1:0] up,
                            logic [PERM_W-1:0] down);
    wait_idle();
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_INCREMENT, up);
    write_reg(CFG_DECREMENT, down);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
      seg_pos = '0;
      seg_acc = '0;
      conn_thr = 8'd128;
      step_up = 8'd8;
      step_down = 8'd4;
    end else begin
      if (tx_mode_left == 0) begin
        tx_mode_left <= $urandom_range(20, 300);
        tx_mode <= $urandom_range(0, 2);
      end else begin
        tx_mode_left <= tx_mode_left - 1;
      end
      if (in_valid && !in_stall) begin
        predict_segment(op_t'(in_cmd), in_input_bit, in_load_value, in_last_bit);
        items_sent <= items_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_bits_q.size() != 0) begin
          drive_bit = pending_bits_q.pop_front();
          in_valid <= 1'b1;
          in_cmd <= drive_bit.op;
          in_input_bit <= drive_bit.in_bit;
          in_load_value <= drive_bit.load_v;
          in_last_bit <= drive_bit.last;
          tx_gap <= rand_gap(tx_mode);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result-side stall, with long hold-offs while the sender keeps streaming
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (items_sent >= next_hold && next_hold <= 1500) begin
        hold_left <= LONG_HOLD;
        next_hold <= next_hold + 1100;
      end
      if (rx_mode_left == 0) begin
        rx_mode_left <= $urandom_range(20, 300);
        rx_mode <= $urandom_range(0, 2);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      if (rx_run != 0) rx_run <= rx_run - 1;
      else rx_run <= rand_gap(rx_mode);
      out_stall <= (hold_left != 0) || (rx_run != 0);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_segment_q.size() == 0) begin
        log_error($sformatf("unexpected result perm=%0d conn=%0d ovl=%0d done=%0d",
                            out_permanence_out, out_connected, out_overlap_count,
                            out_pass_done));
      end else begin
        want = expected_segment_q.pop_front();
        if (out_permanence_out !== want.permanence || out_connected !== want.connected ||
            out_overlap_count !== want.overlap || out_pass_done !== want.pass_done)
          log_error($sformatf({"result mismatch: exp perm=%0d conn=%0d ovl=%0d done=%0d",
                               " got perm=%0d conn=%0d ovl=%0d done=%0d"},
                              want.permanence, want.connected, want.overlap,
                              want.pass_done, out_permanence_out, out_connected,
                              out_overlap_count, out_pass_done));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("htm_segment_overlap_and_learn_test failed");
      $finish;
    end
  end

  initial begin
    int unsigned len, phase_bits, r;
    op_t op;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default settings written explicitly
    set_config(8'd128, 8'd8, 8'd4);
    // load edge permanences, threshold neighbors included
    queue_bit(OP_LOAD, 1'b0, 8'd0,   1'b0);
    queue_bit(OP_LOAD, 1'b1, 8'd255, 1'b0);
    queue_bit(OP_LOAD, 1'b0, 8'd127, 1'b0);
    queue_bit(OP_LOAD, 1'b1, 8'd128, 1'b0);
    queue_bit(OP_LOAD, 1'b0, 8'd250, 1'b0);
    queue_bit(OP_LOAD, 1'b1, 8'd3,   1'b1);
    // overlap pass, ends on an unused command
    queue_bit(OP_OVERLAP, 1'b1, 8'd0,   1'b0);
    queue_bit(OP_OVERLAP, 1'b1, 8'd255, 1'b0);
    queue_bit(OP_OVERLAP, 1'b1, 8'd0,   1'b0);
    queue_bit(OP_OVERLAP, 1'b0, 8'd0,   1'b0);
    queue_bit(OP_OVERLAP, 1'b1, 8'd0,   1'b0);
    queue_bit(OP_NOP,     1'b1, 8'd255, 1'b1);
    // fit and load inside a pass keep the running overlap
    queue_bit(OP_OVERLAP, 1'b1, 8'd0,   1'b0);
    queue_bit(OP_OVERLAP, 1'b1, 8'd0,   1'b0);
    queue_bit(OP_FIT,     1'b1, 8'd0,   1'b0);
    queue_bit(OP_LOAD,    1'b0, 8'd200, 1'b0);
    queue_bit(OP_NOP,     1'b0, 8'd0,   1'b0);
    queue_bit(OP_FIT,     1'b0, 8'd0,   1'b1);
    // fit pass: floor at zero and saturation at the top
    queue_bit(OP_FIT, 1'b0, 8'd0, 1'b0);
    queue_bit(OP_FIT, 1'b1, 8'd0, 1'b0);
    queue_bit(OP_FIT, 1'b1, 8'd0, 1'b0);
    queue_bit(OP_FIT, 1'b0, 8'd0, 1'b0);
    queue_bit(OP_FIT, 1'b1, 8'd0, 1'b0);
    queue_bit(OP_FIT, 1'b0, 8'd0, 1'b1);

    // one long pass: fill the store and wrap past its end
    set_config(8'd0, 8'd0, 8'd0);
    for (int unsigned i = 0; i < NUM_INPUTS; i++)
      queue_bit(OP_LOAD, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0);
    for (int unsigned i = 0; i < 40; i++) begin
      op = ($urandom_range(0, 31) != 0) ? OP_OVERLAP : OP_FIT;
      queue_bit(op, 1'($urandom_range(0, 31) != 0), 8'($urandom_range(0, 255)),
                i == 39);
    end

    // random passes under several settings
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: set_config(8'd255, 8'd255, 8'd255);
        1: set_config(8'd1, 8'd1, 8'd1);
        default: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)));
      endcase
      phase_bits = 0;
      while (phase_bits < 40) begin
        r = $urandom_range(0, 99);
        if (r < 85) len = $urandom_range(1, 24);
        else len = $urandom_range(25, 80);
        queue_pass(len);
        phase_bits += len;
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("htm_segment_overlap_and_learn_test passed");
    end else begin
      $display("htm_segment_overlap_and_learn_test failed");
    end
    $finish;
  end

endmodule
